### rtl/assert_macros.svh
// Assertion macros shared by the keystream XOR block.
// Included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/skx_pkg.sv
// Package for the SHA-1 counter-mode keystream XOR block.
// Holds SHA-1 constants, shared types and the register index codes.
`timescale 1ns / 1ps

package skx_pkg;

	localparam int KEY_W     = 64;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 1'd1;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] PAD_WORD0  = 32'h80000000;
	localparam logic [31:0] PAD_WORD15 = 32'd512;

	// Entry passed from the front end to the back end.
	typedef struct packed {
		logic [7:0] data;
		logic       refresh;   // keystream must be recomputed before this byte
		logic [3:0] pos;
		logic [63:0] counter;
	} skx_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD1,
		ST_RUN1,
		ST_LOAD2,
		ST_RUN2,
		ST_OUT
	} skx_state_t;

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20)      k = 32'h5A827999;
		else if (r < 7'd40) k = 32'h6ED9EBA1;
		else if (r < 7'd60) k = 32'h8F1BBCDC;
		else                k = 32'hCA62C1D6;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20)      f = (b & c) | (~b & d);
		else if (r < 7'd40) f = b ^ c ^ d;
		else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
		else                f = b ^ c ^ d;
		return f;
	endfunction

endpackage

### rtl/skx_front.sv
// Front end: accepts input beats, tracks position and block counter,
// and tags each byte that starts a keystream block. Uses skx_pkg.
`timescale 1ns / 1ps

module skx_front
	import skx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_in,
	input  logic       last_byte,
	output logic       q_push,
	output skx_item_t  q_item,
	input  logic       q_full
);

	logic [63:0] counter_q;
	logic [3:0]  pos_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_item.data    = data_in;
		q_item.refresh = (pos_q == 4'd0);
		q_item.pos     = pos_q;
		q_item.counter = counter_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			pos_q     <= '0;
		end else if (q_push) begin
			if (last_byte) begin
				counter_q <= '0;
				pos_q     <= '0;
			end else begin
				pos_q <= pos_q + 4'd1;
				if (pos_q == 4'd15) counter_q <= counter_q + 64'd1;
			end
		end
	end

endmodule

### rtl/skx_queue.sv
// Short FIFO between the front end and the SHA-1 back end.
// Uses skx_pkg for the entry type.
`timescale 1ns / 1ps

module skx_queue
	import skx_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  skx_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output skx_item_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	skx_item_t        mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

### rtl/skx_back.sv
// Back end: one SHA-1 round per cycle over two compressions, then the XOR
// of each queued byte with its keystream byte. Uses skx_pkg.
`timescale 1ns / 1ps

module skx_back
	import skx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [KEY_W-1:0]  key_a,
	input  logic [KEY_W-1:0]  key_b,
	input  logic              q_empty,
	input  skx_item_t         q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out
);

	skx_state_t state_q, state_d;

	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [5];
	logic [127:0] ks_q;
	logic [6:0]  round_q;
	logic [7:0]  out_q;
	logic        out_valid_q;

	logic        out_free;
	logic [31:0] w_new, w_cur, t_val;
	logic [3:0]  ri;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign data_out  = out_q;

	assign ri    = round_q[3:0];
	assign w_new = {w_q[4'(ri+4'd13)] ^ w_q[4'(ri+4'd8)] ^ w_q[4'(ri+4'd2)] ^ w_q[ri]};
	assign w_cur = (round_q < 7'd16) ? w_q[ri] : {w_new[30:0], w_new[31]};
	assign t_val = {a_q[26:0], a_q[31:27]} + round_f(round_q, b_q, c_q, d_q) + e_q
		+ round_k(round_q) + w_cur;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) state_d = q_head.refresh ? ST_LOAD1 : ST_OUT;
			end
			ST_LOAD1: state_d = ST_RUN1;
			ST_RUN1:  if (round_q == 7'd79) state_d = ST_LOAD2;
			ST_LOAD2: state_d = ST_RUN2;
			ST_RUN2:  if (round_q == 7'd79) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign q_pop = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN1 || state_q == ST_RUN2)
				round_q <= (round_q == 7'd79) ? 7'd0 : round_q + 7'd1;
			else
				round_q <= '0;
			if (q_pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD1: begin
				h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
				a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
				w_q[0] <= key_a[63:32]; w_q[1] <= key_a[31:0];
				w_q[2] <= key_a[63:32]; w_q[3] <= key_a[31:0];
				w_q[4] <= key_b[63:32]; w_q[5] <= key_b[31:0];
				w_q[6] <= key_b[63:32]; w_q[7] <= key_b[31:0];
				for (int i = 8; i < 14; i++) w_q[i] <= '0;
				w_q[14] <= q_head.counter[63:32];
				w_q[15] <= q_head.counter[31:0];
			end
			ST_LOAD2: begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
				a_q <= h_q[0] + a_q; b_q <= h_q[1] + b_q; c_q <= h_q[2] + c_q;
				d_q <= h_q[3] + d_q; e_q <= h_q[4] + e_q;
				w_q[0] <= PAD_WORD0;
				for (int i = 1; i < 15; i++) w_q[i] <= '0;
				w_q[15] <= PAD_WORD15;
			end
			ST_RUN1, ST_RUN2: begin
				if (round_q >= 7'd16) w_q[ri] <= w_cur;
				a_q <= t_val;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
				if (state_q == ST_RUN2 && round_q == 7'd79) begin
					ks_q <= {h_q[0] + t_val, h_q[1] + a_q, h_q[2] + {b_q[1:0], b_q[31:2]},
						h_q[3] + c_q};
				end
			end
			default: begin
			end
		endcase
		if (q_pop) out_q <= q_head.data ^ ks_q[7'(8'd127 - {q_head.pos, 3'd0}) -: 8];
	end

endmodule

### rtl/sha1_counter_keystream_xor_top.sv
// Top level of the SHA-1 counter-mode keystream XOR block.
// Channels: in_valid/in_ready carry data_in and last_byte, out_valid/out_ready
// carry data_out. Key halves are written through cfg_we, cfg_index, cfg_data.
// Each beat yields exactly one output beat, in order.
// A byte at the start of a 16-byte block waits for two SHA-1 compressions
// run one round per cycle in the back end, from reaching the head of the queue
// to the result register. Other bytes go from idle straight to the output
// state there, and the back end handles one queued byte at a time.
// The front end keeps the block counter and byte position and feeds a
// two-entry queue; it stalls only when that queue is full.
// If the receiver holds out_ready low the result stays in the output
// register and the back end stops; input keeps flowing until the queue fills.
// Reset clears counter, position, queue and keys; it is asynchronous, active low.
// A key write affects the next keystream refresh only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1_counter_keystream_xor_top
	import skx_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_in,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out,
	input  logic              cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]  cfg_data
);

	logic [KEY_W-1:0] key_a_q, key_b_q;
	logic      q_push, q_full, q_pop, q_empty;
	skx_item_t q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= '0;
			key_b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_A: key_a_q <= cfg_data;
				REG_KEY_B: key_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	skx_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_in, .last_byte,
		.q_push, .q_item(q_in), .q_full
	);

	skx_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .push(q_push), .push_item(q_in), .full(q_full),
		.pop(q_pop), .empty(q_empty), .head(q_head)
	);

	skx_back u_back (
		.clk, .arst_n, .key_a(key_a_q), .key_b(key_b_q), .q_empty, .q_head, .q_pop,
		.out_valid, .out_ready, .data_out
	);

	`ASSERT_IMPL(a_no_push_full, clk, arst_n, q_full, !q_push, "push into full queue")
	`ASSERT_IMPL(a_no_pop_empty, clk, arst_n, q_pop, !q_empty, "pop from empty queue")
	`ASSERT_NEXT(a_pop_gives_out, clk, arst_n, q_pop, out_valid, "pop without output")

endmodule

### test/sha1_counter_keystream_xor_top_tb.sv
// Self-checking testbench for the SHA-1 counter-mode keystream XOR block.
// Predicts each output byte with its own SHA-1 keystream model; needs only
// the RTL and skx_pkg.
`timescale 1ns / 1ps

module sha1_counter_keystream_xor_top_tb;
	import skx_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 250;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	logic clk, arst_n;
	logic in_valid, in_ready, last_byte, out_valid, out_ready;
	logic [7:0] data_in, data_out;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0] cfg_data;

	byte_beat_t pending_beats[$];
	logic [7:0] expected_bytes[$];

	// Mirror of the block's state.
	logic [63:0] model_key_a, model_key_b, model_counter;
	logic [3:0] model_pos;
	logic [127:0] model_keystream;

	int mismatches;
	int cycle_count;
	int burst_left, gap_left;

	sha1_counter_keystream_xor_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_in(data_in), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready), .data_out(data_out),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [159:0] sha1_compress(input logic [159:0] chain,
		input logic [511:0] msg);
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, k, t;
		{a, b, c, d, e} = chain;
		for (int j = 0; j < 16; j++)
			w[j] = msg[511 - 32*j -: 32];
		for (int r = 0; r < 80; r++) begin
			if (r >= 16)
				w[r % 16] = rotl(w[(r-3) % 16] ^ w[(r-8) % 16] ^ w[(r-14) % 16] ^ w[r % 16], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[r % 16];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		return {chain[159:128] + a, chain[127:96] + b, chain[95:64] + c,
			chain[63:32] + d, chain[31:0] + e};
	endfunction

	// First 16 digest bytes of the 64-byte counter block.
	function automatic logic [127:0] keystream_for(input logic [63:0] ka,
		input logic [63:0] kb, input logic [63:0] ctr);
		logic [159:0] chain;
		chain = {H0, H1, H2, H3, H4};
		chain = sha1_compress(chain, {ka, ka, kb, kb, 192'd0, ctr});
		chain = sha1_compress(chain, {PAD_WORD0, 448'd0, PAD_WORD15});
		return chain[159:32];
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_in <= 8'd0;
			last_byte <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0 || pending_beats.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				byte_beat_t b;
				b = pending_beats.pop_front();
				in_valid <= 1'b1;
				data_in <= b.data;
				last_byte <= b.last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: long stretches of free flow alternate with random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if ((cycle_count / 700) % 3 == 0)
			out_ready <= 1'b1;
		else if ((cycle_count / 700) % 3 == 1)
			out_ready <= ($urandom_range(0, 3) != 0);
		else
			out_ready <= ($urandom_range(0, 9) < 3);
	end

	// Predict one output byte per accepted input beat.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (model_pos == 4'd0)
				model_keystream = keystream_for(model_key_a, model_key_b, model_counter);
			expected_bytes.push_back(data_in ^ model_keystream[127 - 8*model_pos -: 8]);
			model_pos = model_pos + 4'd1;
			if (model_pos == 4'd0)
				model_counter = model_counter + 64'd1;
			if (last_byte) begin
				model_counter = 64'd0;
				model_pos = 4'd0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: data_out=%02h", data_out);
			end else begin
				logic [7:0] want;
				want = expected_bytes.pop_front();
				if (data_out !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("data_out mismatch: expected %02h, got %02h", want, data_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sha1_counter_keystream_xor_top_tb: done, errors");
			$finish;
		end
	end

	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_KEY_A)
			model_key_a = value;
		else
			model_key_b = value;
	endtask

	task automatic add_beat(input logic [7:0] data, input logic last);
		byte_beat_t b;
		b.data = data;
		b.last = last;
		pending_beats.push_back(b);
	endtask

	task automatic add_stream(input int len, input logic ends);
		for (int j = 0; j < len; j++)
			add_beat(8'($urandom_range(0, 255)), ends && (j == len - 1));
	endtask

	// Let the block go idle so a key write cannot touch bytes in flight.
	task automatic drain;
		while (pending_beats.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int count;
		logic [63:0] ka, kb;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_A;
		cfg_data = '0;
		model_key_a = '0;
		model_key_b = '0;
		model_counter = '0;
		model_pos = '0;
		model_keystream = '0;
		mismatches = 0;
		cycle_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single-byte stream, extreme bytes, a stream crossing
		// a block boundary, and a stream ending mid-block.
		add_beat(8'h00, 1'b1);
		add_beat(8'hFF, 1'b1);
		add_beat(8'h55, 1'b0);
		add_beat(8'hAA, 1'b0);
		for (int j = 0; j < 16; j++)
			add_beat(j[0] ? 8'hFF : 8'h00, 1'b0);
		add_beat(8'h5A, 1'b1);
		add_beat(8'hA5, 1'b0);
		add_beat(8'h0F, 1'b1);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin ka = '1; kb = '1; end
				1: begin ka = 64'h0; kb = 64'hFFFF_FFFF_FFFF_FFFF; end
				2: begin ka = 64'hAAAA_AAAA_AAAA_AAAA; kb = 64'h5555_5555_5555_5555; end
				default: begin ka = {$urandom, $urandom}; kb = {$urandom, $urandom}; end
			endcase
			write_key(REG_KEY_A, ka);
			write_key(REG_KEY_B, kb);
			count = 0;
			while (count < 280) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
					: $urandom_range(1, 24);
				// Some streams run on without an end marker.
				add_stream(len, $urandom_range(0, 9) != 0);
				count += len;
			end
			add_beat(8'($urandom_range(0, 255)), 1'b1);
			drain();
		end

		if (mismatches == 0 && expected_bytes.size() == 0)
			$display("sha1_counter_keystream_xor_top_tb: done, clean");
		else
			$display("sha1_counter_keystream_xor_top_tb: done, errors");
		$finish;
	end

endmodule
